// ----- hw/rtl/afskm_pkg.sv -----
// ----------------------------------------------------------------------------
// afskm_pkg
// Shared types, constants and the sine table of the AFSK NRZI tone modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package afskm_pkg;

  localparam int unsigned PhaseW    = 16;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned BaudW     = 24;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BitPosW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CfgAddrW  = 2;

  // tone table depth (power of two, 64 to 4096) and the fixed rom behind it
  localparam int unsigned SineDepth = 512;
  localparam int unsigned SineAw    = $clog2(SineDepth);
  localparam int unsigned SineRomSize = 512;
  localparam int unsigned SineRomAw   = $clog2(SineRomSize);

  localparam logic [BaudW-1:0]   OneFixed      = BaudW'(256);
  localparam logic [SampleW-1:0] EmphOffset    = SampleW'(16384);

  localparam logic [BaudW-1:0]   SpbReset      = BaudW'(2048);
  localparam logic [PhaseW-1:0]  MarkIncReset  = PhaseW'(8192);
  localparam logic [PhaseW-1:0]  ToggleReset   = PhaseW'(6827);

  typedef enum logic [CfgAddrW-1:0] {
    CfgSamplesPerBaud = 2'd0,
    CfgMarkIncrement  = 2'd1,
    CfgToneToggleMask = 2'd2,
    CfgPreEmphasis    = 2'd3
  } cfg_idx_e;

  // result flags, highest bit first
  typedef struct packed {
    logic end_of_data;
    logic byte_consumed;
    logic sample_valid;
  } res_flags_t;

  localparam logic [SampleW-1:0] SineRom [SineRomSize] = '{
    16'd32767, 16'd33169, 16'd33571, 16'd33973, 16'd34375, 16'd34776, 16'd35178, 16'd35578,
    16'd35979, 16'd36379, 16'd36778, 16'd37177, 16'd37575, 16'd37972, 16'd38369, 16'd38765,
    16'd39160, 16'd39554, 16'd39946, 16'd40338, 16'd40729, 16'd41118, 16'd41507, 16'd41893,
    16'd42279, 16'd42663, 16'd43046, 16'd43427, 16'd43806, 16'd44184, 16'd44560, 16'd44934,
    16'd45307, 16'd45677, 16'd46046, 16'd46412, 16'd46777, 16'd47139, 16'd47500, 16'd47858,
    16'd48213, 16'd48567, 16'd48918, 16'd49267, 16'd49613, 16'd49956, 16'd50298, 16'd50636,
    16'd50972, 16'd51305, 16'd51635, 16'd51962, 16'd52287, 16'd52608, 16'd52927, 16'd53242,
    16'd53554, 16'd53864, 16'd54170, 16'd54473, 16'd54772, 16'd55069, 16'd55362, 16'd55651,
    16'd55937, 16'd56220, 16'd56499, 16'd56774, 16'd57046, 16'd57314, 16'd57579, 16'd57840,
    16'd58097, 16'd58350, 16'd58599, 16'd58845, 16'd59086, 16'd59324, 16'd59557, 16'd59787,
    16'd60012, 16'd60234, 16'd60451, 16'd60664, 16'd60873, 16'd61077, 16'd61278, 16'd61474,
    16'd61665, 16'd61853, 16'd62036, 16'd62214, 16'd62388, 16'd62558, 16'd62723, 16'd62884,
    16'd63040, 16'd63192, 16'd63339, 16'd63481, 16'd63619, 16'd63752, 16'd63881, 16'd64004,
    16'd64124, 16'd64238, 16'd64348, 16'd64452, 16'd64552, 16'd64648, 16'd64738, 16'd64824,
    16'd64905, 16'd64981, 16'd65052, 16'd65118, 16'd65180, 16'd65236, 16'd65288, 16'd65335,
    16'd65377, 16'd65414, 16'd65446, 16'd65473, 16'd65495, 16'd65512, 16'd65525, 16'd65532,
    16'd65535, 16'd65532, 16'd65525, 16'd65512, 16'd65495, 16'd65473, 16'd65446, 16'd65414,
    16'd65377, 16'd65335, 16'd65288, 16'd65236, 16'd65180, 16'd65118, 16'd65052, 16'd64981,
    16'd64905, 16'd64824, 16'd64738, 16'd64648, 16'd64552, 16'd64452, 16'd64348, 16'd64238,
    16'd64124, 16'd64004, 16'd63881, 16'd63752, 16'd63619, 16'd63481, 16'd63339, 16'd63192,
    16'd63040, 16'd62884, 16'd62723, 16'd62558, 16'd62388, 16'd62214, 16'd62036, 16'd61853,
    16'd61665, 16'd61474, 16'd61278, 16'd61077, 16'd60873, 16'd60664, 16'd60451, 16'd60234,
    16'd60012, 16'd59787, 16'd59557, 16'd59324, 16'd59086, 16'd58845, 16'd58599, 16'd58350,
    16'd58097, 16'd57840, 16'd57579, 16'd57314, 16'd57046, 16'd56774, 16'd56499, 16'd56220,
    16'd55937, 16'd55651, 16'd55362, 16'd55069, 16'd54772, 16'd54473, 16'd54170, 16'd53864,
    16'd53554, 16'd53242, 16'd52927, 16'd52608, 16'd52287, 16'd51962, 16'd51635, 16'd51305,
    16'd50972, 16'd50636, 16'd50298, 16'd49956, 16'd49613, 16'd49267, 16'd48918, 16'd48567,
    16'd48213, 16'd47858, 16'd47500, 16'd47139, 16'd46777, 16'd46412, 16'd46046, 16'd45677,
    16'd45307, 16'd44934, 16'd44560, 16'd44184, 16'd43806, 16'd43427, 16'd43046, 16'd42663,
    16'd42279, 16'd41893, 16'd41507, 16'd41118, 16'd40729, 16'd40338, 16'd39946, 16'd39554,
    16'd39160, 16'd38765, 16'd38369, 16'd37972, 16'd37575, 16'd37177, 16'd36778, 16'd36379,
    16'd35979, 16'd35578, 16'd35178, 16'd34776, 16'd34375, 16'd33973, 16'd33571, 16'd33169,
    16'd32767, 16'd32365, 16'd31963, 16'd31561, 16'd31159, 16'd30758, 16'd30356, 16'd29956,
    16'd29555, 16'd29155, 16'd28756, 16'd28357, 16'd27959, 16'd27562, 16'd27165, 16'd26769,
    16'd26374, 16'd25980, 16'd25588, 16'd25196, 16'd24805, 16'd24416, 16'd24027, 16'd23641,
    16'd23255, 16'd22871, 16'd22488, 16'd22107, 16'd21728, 16'd21350, 16'd20974, 16'd20600,
    16'd20227, 16'd19857, 16'd19488, 16'd19122, 16'd18757, 16'd18395, 16'd18034, 16'd17676,
    16'd17321, 16'd16967, 16'd16616, 16'd16267, 16'd15921, 16'd15578, 16'd15236, 16'd14898,
    16'd14562, 16'd14229, 16'd13899, 16'd13572, 16'd13247, 16'd12926, 16'd12607, 16'd12292,
    16'd11980, 16'd11670, 16'd11364, 16'd11061, 16'd10762, 16'd10465, 16'd10172, 16'd9883,
    16'd9597,  16'd9314,  16'd9035,  16'd8760,  16'd8488,  16'd8220,  16'd7955,  16'd7694,
    16'd7437,  16'd7184,  16'd6935,  16'd6689,  16'd6448,  16'd6210,  16'd5977,  16'd5747,
    16'd5522,  16'd5300,  16'd5083,  16'd4870,  16'd4661,  16'd4457,  16'd4256,  16'd4060,
    16'd3869,  16'd3681,  16'd3498,  16'd3320,  16'd3146,  16'd2976,  16'd2811,  16'd2650,
    16'd2494,  16'd2342,  16'd2195,  16'd2053,  16'd1915,  16'd1782,  16'd1653,  16'd1530,
    16'd1410,  16'd1296,  16'd1186,  16'd1082,  16'd982,   16'd886,   16'd796,   16'd710,
    16'd629,   16'd553,   16'd482,   16'd416,   16'd354,   16'd298,   16'd246,   16'd199,
    16'd157,   16'd120,   16'd88,    16'd61,    16'd39,    16'd22,    16'd9,     16'd2,
    16'd0,     16'd2,     16'd9,     16'd22,    16'd39,    16'd61,    16'd88,    16'd120,
    16'd157,   16'd199,   16'd246,   16'd298,   16'd354,   16'd416,   16'd482,   16'd553,
    16'd629,   16'd710,   16'd796,   16'd886,   16'd982,   16'd1082,  16'd1186,  16'd1296,
    16'd1410,  16'd1530,  16'd1653,  16'd1782,  16'd1915,  16'd2053,  16'd2195,  16'd2342,
    16'd2494,  16'd2650,  16'd2811,  16'd2976,  16'd3146,  16'd3320,  16'd3498,  16'd3681,
    16'd3869,  16'd4060,  16'd4256,  16'd4457,  16'd4661,  16'd4870,  16'd5083,  16'd5300,
    16'd5522,  16'd5747,  16'd5977,  16'd6210,  16'd6448,  16'd6689,  16'd6935,  16'd7184,
    16'd7437,  16'd7694,  16'd7955,  16'd8220,  16'd8488,  16'd8760,  16'd9035,  16'd9314,
    16'd9597,  16'd9883,  16'd10172, 16'd10465, 16'd10762, 16'd11061, 16'd11364, 16'd11670,
    16'd11980, 16'd12292, 16'd12607, 16'd12926, 16'd13247, 16'd13572, 16'd13899, 16'd14229,
    16'd14562, 16'd14898, 16'd15236, 16'd15578, 16'd15921, 16'd16267, 16'd16616, 16'd16967,
    16'd17321, 16'd17676, 16'd18034, 16'd18395, 16'd18757, 16'd19122, 16'd19488, 16'd19857,
    16'd20227, 16'd20600, 16'd20974, 16'd21350, 16'd21728, 16'd22107, 16'd22488, 16'd22871,
    16'd23255, 16'd23641, 16'd24027, 16'd24416, 16'd24805, 16'd25196, 16'd25588, 16'd25980,
    16'd26374, 16'd26769, 16'd27165, 16'd27562, 16'd27959, 16'd28357, 16'd28756, 16'd29155,
    16'd29555, 16'd29956, 16'd30356, 16'd30758, 16'd31159, 16'd31561, 16'd31963, 16'd32365
  };

endpackage

`default_nettype wire

// ----- hw/rtl/afskm_sine_lut.sv -----
// ----------------------------------------------------------------------------
// afskm_sine_lut
// Phase to sample lookup with optional mark tone pre-emphasis.
// ----------------------------------------------------------------------------
`default_nettype none

module afskm_sine_lut import afskm_pkg::*; (
  input  wire logic [PhaseW-1:0]  phase_i,
  input  wire logic               emph_i,
  output logic      [SampleW-1:0] sample_o
);

  logic [SineRomAw-1:0] rom_pos;
  logic [SampleW-1:0]   rom_data;

  // top table-index bits of the phase, spread over the fixed rom
  if (SineAw >= SineRomAw) begin : g_deep
    assign rom_pos = phase_i[PhaseW-1 -: SineRomAw];
  end else begin : g_shallow
    assign rom_pos = {phase_i[PhaseW-1 -: SineAw], {(SineRomAw-SineAw){1'b0}}};
  end

  assign rom_data = SineRom[rom_pos];

  // halve and lift the mark tone
  assign sample_o = emph_i ? ({1'b0, rom_data[SampleW-1:1]} + EmphOffset) : rom_data;

endmodule

`default_nettype wire

// ----- hw/rtl/afsk_nrzi_tone_modulator.sv -----
// ----------------------------------------------------------------------------
// afsk_nrzi_tone_modulator
// AFSK modulator with NRZI coding, table-driven tone generator, stream ports.
// ----------------------------------------------------------------------------
// Each input word is one audio sample tick carrying the next message byte
// (tdata) and its present flag (tuser); each tick gives one result word with
// the sample in tdata and the flags sample_valid, byte_consumed, end_of_data
// in tuser bits 0, 1, 2. The block takes one word per clock while the result side
// keeps accepting: a word lands in an input register, the tick is worked out in one
// pass (bit load or shift, NRZI tone swap, phase add, sine table, baud counter)
// and lands in the result register.
// s_axis_tready follows m_axis_tready in the same cycle when both registers
// are full. Configuration writes are taken at any time but belong to idle
// periods; writing the mark increment does not change the running tone.
// ----------------------------------------------------------------------------
`default_nettype none

module afsk_nrzi_tone_modulator import afskm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // input ticks
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ByteW-1:0]    s_axis_tdata,   // next_byte
  input  wire logic [0:0]          s_axis_tuser,   // byte_available
  // results
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [SampleW-1:0]       m_axis_tdata,   // sample
  output logic [2:0]               m_axis_tuser    // sample_valid, byte_consumed, end_of_data
);

  // configuration registers
  logic [BaudW-1:0]  spb_q;
  logic [PhaseW-1:0] mark_inc_q;
  logic [PhaseW-1:0] toggle_q;
  logic              emph_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spb_q      <= SpbReset;
      mark_inc_q <= MarkIncReset;
      toggle_q   <= ToggleReset;
      emph_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgSamplesPerBaud: spb_q      <= cfg_wdata_i[BaudW-1:0];
        CfgMarkIncrement:  mark_inc_q <= cfg_wdata_i[PhaseW-1:0];
        CfgToneToggleMask: toggle_q   <= cfg_wdata_i[PhaseW-1:0];
        CfgPreEmphasis:    emph_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_avail_q;
  logic             out_load;
  logic             in_load;

  assign out_load      = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q  <= s_axis_tdata;
      in_avail_q <= s_axis_tuser[0];
    end
  end

  // modulator state
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [PhaseW-1:0]  tone_q, tone_d;
  logic [BaudW-1:0]   baud_q, baud_d;
  logic [BitPosW-1:0] bitpos_q, bitpos_d;
  logic [ByteW-1:0]   shift_q, shift_d;

  logic               boundary;
  logic               eod;
  logic               consumed;
  logic [BaudW:0]     baud_sum;
  logic               baud_wrap;
  logic [SampleW-1:0] lut_sample;

  always_comb begin
    boundary = (baud_q < OneFixed);
    eod      = boundary && (bitpos_q == '0) && !in_avail_q;
    consumed = boundary && (bitpos_q == '0) && in_avail_q;

    shift_d = shift_q;
    tone_d  = tone_q;
    if (boundary) begin
      shift_d = (bitpos_q == '0) ? in_byte_q : (shift_q >> 1);
      // nrzi: a zero bit swaps mark and space
      if (!shift_d[0]) begin
        tone_d = tone_q ^ toggle_q;
      end
    end

    phase_d = phase_q + tone_d;

    baud_sum  = {1'b0, baud_q} + {1'b0, OneFixed};
    baud_wrap = (baud_sum >= {1'b0, spb_q});
    baud_d    = baud_wrap ? BaudW'(baud_sum - {1'b0, spb_q}) : baud_sum[BaudW-1:0];
    bitpos_d  = baud_wrap ? bitpos_q + BitPosW'(1) : bitpos_q;
  end

  afskm_sine_lut u_sine_lut (
    .phase_i  (phase_d),
    .emph_i   (emph_en_q && (tone_d == mark_inc_q)),
    .sample_o (lut_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      tone_q   <= MarkIncReset;
      baud_q   <= '0;
      bitpos_q <= '0;
      shift_q  <= '0;
    end else if (out_load && !eod) begin
      phase_q  <= phase_d;
      tone_q   <= tone_d;
      baud_q   <= baud_d;
      bitpos_q <= bitpos_d;
      shift_q  <= shift_d;
    end
  end

  // result register
  logic               out_valid_q;
  logic [SampleW-1:0] out_sample_q;
  res_flags_t         out_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q              <= eod ? '0 : lut_sample;
      out_flags_q.sample_valid  <= !eod;
      out_flags_q.byte_consumed <= consumed;
      out_flags_q.end_of_data   <= eod;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = out_flags_q;

  // end of data leaves the modulator state alone
  a_eod_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && eod) |=> ($stable(phase_q) && $stable(tone_q) && $stable(bitpos_q)))
    else $error("state changed on end of data");

  // bit position only moves when the baud counter wraps
  a_bitpos_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !eod && !baud_wrap) |=> $stable(bitpos_q))
    else $error("bit position moved without baud wrap");

  // a result flags exactly one of sample and end of data
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] != m_axis_tuser[2]))
    else $error("sample_valid and end_of_data inconsistent");

  // a consumed byte always comes with a sample
  a_consume_has_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tuser[0])
    else $error("byte consumed without sample");

  // a byte is only taken at bit position zero
  a_consume_at_bit0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && consumed) |-> (bitpos_q == '0))
    else $error("byte taken away from bit zero");

endmodule

`default_nettype wire

// ----- bench/afsk_nrzi_tone_modulator_tb.sv -----
// ----------------------------------------------------------------------------
// afsk_nrzi_tone_modulator_tb
// Self-checking bench for the AFSK NRZI tone modulator.
// ----------------------------------------------------------------------------
// A scoreboard class carries its own copy of the modulator state (phase, tone
// increment, baud counter, bit position, shift byte) and works out the sample
// word each accepted tick must give. Ticks are sent in phases; between phases
// the block is drained and the registers are rewritten. Both stream sides
// idle at random, and the receiver holds off once for a long stretch so the
// block backs up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module afsk_nrzi_tone_modulator_tb import afskm_pkg::*; ;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    res_flags_t         flags;
  } tone_word_t;

  class sample_scoreboard;
    logic [BaudW-1:0]   spb;
    logic [PhaseW-1:0]  mark_inc;
    logic [PhaseW-1:0]  toggle_mask;
    logic               pre_emph;
    logic [PhaseW-1:0]  phase;
    logic [PhaseW-1:0]  tone_inc;
    logic [BaudW-1:0]   baud;
    logic [BitPosW-1:0] bit_pos;
    logic [ByteW-1:0]   shift_q;
    tone_word_t         samples_due[$];
    int                 errors;

    function void clear();
      spb         = SpbReset;
      mark_inc    = MarkIncReset;
      toggle_mask = ToggleReset;
      pre_emph    = 1'b0;
      phase       = '0;
      tone_inc    = MarkIncReset;
      baud        = '0;
      bit_pos     = '0;
      shift_q     = '0;
      errors      = 0;
      samples_due.delete();
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CfgSamplesPerBaud: spb = val[BaudW-1:0];
        CfgMarkIncrement:  mark_inc = val[PhaseW-1:0];
        CfgToneToggleMask: toggle_mask = val[PhaseW-1:0];
        CfgPreEmphasis:    pre_emph = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return samples_due.size();
    endfunction

    function void note_tick(logic [ByteW-1:0] next_byte, logic avail);
      tone_word_t      w;
      logic [BaudW:0]  sum;
      int unsigned     idx;
      int unsigned     pos;
      logic [SampleW-1:0] s;
      w = '0;
      if (baud < OneFixed) begin
        if (bit_pos == '0) begin
          // no byte at a byte boundary: flag it and leave the state alone
          if (!avail) begin
            w.flags.end_of_data = 1'b1;
            samples_due.push_back(w);
            return;
          end
          shift_q = next_byte;
          w.flags.byte_consumed = 1'b1;
        end else begin
          shift_q = shift_q >> 1;
        end
        if (!shift_q[0]) tone_inc = tone_inc ^ toggle_mask;
      end
      phase = phase + tone_inc;
      idx = (32'(phase) * SineDepth) >> PhaseW;
      pos = (idx * SineRomSize) / SineDepth;
      s = SineRom[pos % SineRomSize];
      if (pre_emph && tone_inc == mark_inc) s = (s >> 1) + EmphOffset;
      sum = {1'b0, baud} + {1'b0, OneFixed};
      if (sum >= {1'b0, spb}) begin
        bit_pos = bit_pos + 1'b1;
        sum = sum - {1'b0, spb};
      end
      baud = sum[BaudW-1:0];
      w.sample = s;
      w.flags.sample_valid = 1'b1;
      samples_due.push_back(w);
    endfunction

    function void check_sample(logic [SampleW-1:0] sample, logic [2:0] flags);
      tone_word_t exp_w;
      res_flags_t got;
      got = flags;
      if (samples_due.size() == 0) begin
        $error("unexpected result word: sample %0d flags %b", sample, flags);
        errors++;
        return;
      end
      exp_w = samples_due.pop_front();
      if (sample !== exp_w.sample) begin
        $error("sample: expected %0d, got %0d", exp_w.sample, sample);
        errors++;
      end
      if (got.sample_valid !== exp_w.flags.sample_valid) begin
        $error("sample_valid: expected %0b, got %0b", exp_w.flags.sample_valid,
               got.sample_valid);
        errors++;
      end
      if (got.byte_consumed !== exp_w.flags.byte_consumed) begin
        $error("byte_consumed: expected %0b, got %0b", exp_w.flags.byte_consumed,
               got.byte_consumed);
        errors++;
      end
      if (got.end_of_data !== exp_w.flags.end_of_data) begin
        $error("end_of_data: expected %0b, got %0b", exp_w.flags.end_of_data,
               got.end_of_data);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_valid   = 1'b0;
  logic                s_ready;
  logic [ByteW-1:0]    s_data    = '0;
  logic [0:0]          s_user    = '0;
  logic                m_valid;
  logic                m_ready   = 1'b0;
  logic [SampleW-1:0]  m_data;
  logic [2:0]          m_user;

  logic                hold_off  = 1'b0;
  int                  ticks_sent = 0;
  int                  tx_run = 0;
  bit                  tx_fast = 1'b0;
  int                  rx_run = 0;
  bit                  rx_fast = 1'b0;

  sample_scoreboard sb = new;

  afsk_nrzi_tone_modulator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),    // next_byte
    .s_axis_tuser  (s_user),    // byte_available
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),    // sample
    .m_axis_tuser  (m_user)     // sample_valid, byte_consumed, end_of_data
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // runs of back-to-back words mixed with runs of random gaps
  function automatic int draw_gap(inout int run_left, inout bit no_idle);
    if (run_left == 0) begin
      no_idle  = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 60);
    end
    run_left--;
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic send_tick(logic [ByteW-1:0] next_byte, logic avail);
    int gap;
    gap = draw_gap(tx_run, tx_fast);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= next_byte;
    s_user  <= avail;
    do @(posedge clk_i); while (!(s_valid && s_ready));
    sb.note_tick(next_byte, avail);
    ticks_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    s_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_all(logic [BaudW-1:0] spb, logic [PhaseW-1:0] mark,
                           logic [PhaseW-1:0] mask, logic pre);
    cfg_idx_e            regs[4];
    logic [CfgDataW-1:0] vals[4];
    regs = '{CfgSamplesPerBaud, CfgMarkIncrement, CfgToneToggleMask, CfgPreEmphasis};
    vals = '{spb, CfgDataW'(mark), CfgDataW'(mask), CfgDataW'(pre)};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[k];
      cfg_wdata <= vals[k];
      @(posedge clk_i);
      sb.set_reg(regs[k], vals[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // receiver
  initial begin
    int gap;
    forever begin
      gap = draw_gap(rx_run, rx_fast);
      if (hold_off || gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_valid && m_ready));
      sb.check_sample(m_data, m_user);
    end
  end

  // long receiver hold-off partway through, sender keeps offering
  initial begin
    wait (ticks_sent >= 600);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [BaudW-1:0]  spb;
    logic [PhaseW-1:0] mark;
    logic [PhaseW-1:0] mask;
    int                n;
    int                drop_pct;
    sb.clear();
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset settings: no byte at the first boundary, then a load
    send_tick(8'h3C, 1'b0);
    send_tick(8'h00, 1'b1);
    send_tick(8'hFF, 1'b0);
    settle();

    // one bit per tick, mark tone emphasized
    write_all(24'd256, MarkIncReset, ToggleReset, 1'b1);
    send_tick(8'h00, 1'b1);
    repeat (7) send_tick(8'($urandom), 1'($urandom_range(0, 1)));
    send_tick(8'hFF, 1'b1);
    repeat (7) send_tick(8'($urandom), 1'($urandom_range(0, 1)));
    send_tick(8'h81, 1'b0);
    settle();

    // slowest baud, widest increments: counter climbs well above a later bound
    write_all(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    repeat (4) send_tick(8'($urandom), 1'b1);
    settle();
    write_all(24'd600, sb.mark_inc, sb.toggle_mask, sb.pre_emph);
    repeat (5) send_tick(8'($urandom), 1'b1);
    settle();

    // bound below one sample: counter wraps
    write_all(24'd128, 16'h0000, 16'h0000, 1'b1);
    repeat (3) send_tick(8'($urandom), 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      settle();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: spb = 24'd256;
        4, 5, 6:    spb = 24'($urandom_range(257, 1200));
        7:          spb = 24'($urandom_range(1201, 4096));
        8:          spb = 24'hFFFFFF;
        default:    spb = 24'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       mark = 16'h0000;
        1:       mark = 16'hFFFF;
        2, 3:    mark = sb.tone_inc;
        default: mark = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       mask = 16'h0000;
        1:       mask = 16'hFFFF;
        default: mask = 16'($urandom);
      endcase
      if (ph == 0) begin
        spb = 24'd256;
        mask = 16'hFFFF;
      end
      write_all(spb, mark, mask, 1'($urandom_range(0, 1)));
      // mostly steady byte supply, one phase with frequent gaps in the data
      drop_pct = (ph == 5) ? 50 : $urandom_range(3, 15);
      n = $urandom_range(130, 180);
      repeat (n) send_tick(8'($urandom), $urandom_range(0, 99) >= drop_pct);
    end
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
